/* src/mbce_pkg.sv */
// Package for the monochrome bitmap color expansion block: sizes and register indexes.
package mbce_pkg;

	localparam int COORD_BITS = 10;
	localparam int MAX_STRIDE = 128;

	localparam int PIX_W      = COORD_BITS + 1;
	localparam int BYTE_IDX_W = (MAX_STRIDE > 2) ? $clog2(MAX_STRIDE) : 1;
	localparam int COL_W      = BYTE_IDX_W + 3;
	localparam int STRIDE_W   = 8;
	localparam int COLOR_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CMP_W      = ((COL_W > COORD_BITS) ? COL_W : COORD_BITS) + 1;
	localparam int CNT_W      = ((BYTE_IDX_W > STRIDE_W) ? BYTE_IDX_W : STRIDE_W) + 1;

	localparam logic [7:0] TOP_BIT = 8'h80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_BITMAP_WIDTH  = 3'd2,
		REG_BITMAP_HEIGHT = 3'd3,
		REG_ROW_STRIDE    = 3'd4,
		REG_DRAW_COLOR    = 3'd5
	} cfg_reg_t;

	localparam logic [COORD_BITS-1:0] RST_WIDTH  = COORD_BITS'(8);
	localparam logic [COORD_BITS-1:0] RST_HEIGHT = COORD_BITS'(8);
	localparam logic [STRIDE_W-1:0]   RST_STRIDE = STRIDE_W'(1);
	localparam logic [COLOR_W-1:0]    RST_COLOR  = '1;

endpackage

/* src/mono_bitmap_color_expand_core.sv */
// Top level: expands bitmap bytes into one pixel write per set, in-width bit.
// A byte accepted into stage 1 is expanded there; each pixel write is registered in stage 2.
// Throughput: one pixel write per cycle while out_stall is low; a byte holds the input until
// its last write leaves the single bit-pick stage (a byte with no writes does not occupy it).
// Reset (arst_n, asynchronous, active low) clears the row position, empties both stages and
// loads the register defaults: width 8, height 8, stride 1, color all ones, origin zero.
module mono_bitmap_color_expand_core
	import mbce_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// bitmap bytes
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            bitmap_byte,
	// pixel writes
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_x,
	output logic [PIX_W-1:0]      pixel_y,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  last_of_byte
);

	logic [COORD_BITS-1:0] origin_x_q, origin_y_q, width_q, height_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [COLOR_W-1:0]    color_q;

	logic [BYTE_IDX_W-1:0] byte_idx_q;
	logic [COORD_BITS-1:0] row_q;

	logic                  valid_s1;
	logic [7:0]            mask_s1;
	logic [BYTE_IDX_W-1:0] byte_s1;
	logic [PIX_W-1:0]      py_s1;

	logic                  valid_s2;
	logic [PIX_W-1:0]      px_s2, py_s2;
	logic [COLOR_W-1:0]    color_s2;
	logic                  last_s2;

	logic                  in_accept, advance;
	logic [7:0]            new_mask, remaining;
	logic [2:0]            pick;
	logic                  found;
	logic [CNT_W-1:0]      stride_eff, byte_next;
	logic [PIX_W-1:0]      row_next;
	logic                  end_of_row;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
			stride_q   <= RST_STRIDE;
			color_q    <= RST_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_X:      origin_x_q <= cfg_data[COORD_BITS-1:0];
				REG_ORIGIN_Y:      origin_y_q <= cfg_data[COORD_BITS-1:0];
				REG_BITMAP_WIDTH:  width_q    <= cfg_data[COORD_BITS-1:0];
				REG_BITMAP_HEIGHT: height_q   <= cfg_data[COORD_BITS-1:0];
				REG_ROW_STRIDE:    stride_q   <= cfg_data[STRIDE_W-1:0];
				REG_DRAW_COLOR:    color_q    <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// bits of the incoming byte that land inside the bitmap width
	always_comb begin
		logic [COL_W-1:0] col;
		for (int b = 0; b < 8; b++) begin
			col = {byte_idx_q, 3'(b)};
			new_mask[7-b] = bitmap_byte[7-b] && (CMP_W'(col) < CMP_W'(width_q));
		end
	end

	// leftmost pending bit of the byte in stage 1
	always_comb begin
		pick  = 3'd0;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!found && mask_s1[7-i]) begin
				pick  = 3'(i);
				found = 1'b1;
			end
		end
		remaining = mask_s1 & ~(TOP_BIT >> pick);
	end

	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !(advance && (remaining == 8'd0));
	assign in_accept = in_valid && !in_stall;

	// row position bookkeeping; stride of zero acts as one, large strides saturate
	always_comb begin
		if (stride_q == '0)
			stride_eff = CNT_W'(1);
		else if (CNT_W'(stride_q) > CNT_W'(MAX_STRIDE))
			stride_eff = CNT_W'(MAX_STRIDE);
		else
			stride_eff = CNT_W'(stride_q);
		byte_next  = CNT_W'(byte_idx_q) + CNT_W'(1);
		end_of_row = byte_next >= stride_eff;
		row_next   = PIX_W'(row_q) + PIX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			row_q      <= '0;
		end else if (in_accept) begin
			if (end_of_row) begin
				byte_idx_q <= '0;
				if (row_next >= PIX_W'(height_q))
					row_q <= '0;
				else
					row_q <= row_next[COORD_BITS-1:0];
			end else begin
				byte_idx_q <= byte_next[BYTE_IDX_W-1:0];
			end
		end
	end

	// stage 1: byte being expanded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= |new_mask;
		end else if (valid_s1 && advance) begin
			valid_s1 <= |remaining;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mask_s1 <= new_mask;
			byte_s1 <= byte_idx_q;
			py_s1   <= PIX_W'(origin_y_q) + PIX_W'(row_q);
		end else if (valid_s1 && advance) begin
			mask_s1 <= remaining;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			px_s2    <= PIX_W'(origin_x_q) + PIX_W'({byte_s1, pick});
			py_s2    <= py_s1;
			color_s2 <= color_q;
			last_s2  <= (remaining == 8'd0);
		end
	end

	assign out_valid    = valid_s2;
	assign pixel_x      = px_s2;
	assign pixel_y      = py_s2;
	assign pixel_color  = color_s2;
	assign last_of_byte = last_s2;

`ifndef SYNTHESIS
	// stage 1 only holds bytes that still owe a pixel write
	a_s1_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (mask_s1 != 8'd0))
		else $error("stage 1 valid with empty bit mask");

	// a non-final pixel on the output means the rest of its byte is still pending
	a_rest_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !last_s2) |-> valid_s1)
		else $error("non-final pixel transaction without pending bits");

	// a new byte is taken while busy only when the last bit leaves stage 1
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && valid_s1) |-> (advance && (remaining == 8'd0)))
		else $error("byte accepted while stage 1 still busy");
`endif

endmodule
